// ----- rtl/core/adc_pkg.sv -----
// ----------------------------------------------------------------------------
// adc_pkg: shared types and constants of the dynamics compander
// Register indexes, controller states and the word handed along the row of
// Bezier search cells.
// ----------------------------------------------------------------------------
`default_nettype none

package adc_pkg;

   // Q1.16 unity and the early-stop tolerance of the search (0.001 in Q1.16)
   localparam int Q16_ONE    = 65536;
   localparam int SEARCH_TOL = 66;

   // width of a curve value, signed, wide enough for every knee setting
   localparam int OVAL_W = 28;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_KNEE_MODE   = 3'd0,
      CSR_LOUD_BASE   = 3'd1,
      CSR_LOUD_DEPTH  = 3'd2,
      CSR_QUIET_BASE  = 3'd3,
      CSR_QUIET_DEPTH = 3'd4,
      CSR_THR_BASE    = 3'd5,
      CSR_THR_DEPTH   = 3'd6
   } csr_index_type;

   // controller states
   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_MOD   = 11'b000_0000_0010,
      ST_KNEE  = 11'b000_0000_0100,
      ST_CLAMP = 11'b000_0000_1000,
      ST_DIV   = 11'b000_0001_0000,
      ST_GAIN  = 11'b000_0010_0000,
      ST_CHAIN = 11'b000_0100_0000,
      ST_FIN1  = 11'b000_1000_0000,
      ST_FIN2  = 11'b001_0000_0000,
      ST_FIN3  = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

   // word handed from one search cell to the next
   typedef struct packed {
      logic        valid;
      logic        done;
      logic [16:0] lo;
      logic [16:0] hi;
      logic [16:0] t;
   } search_word_type;

endpackage

`default_nettype wire

// ----- rtl/core/adc_search_cell.sv -----
// ----------------------------------------------------------------------------
// adc_search_cell: one halving step of the Bezier parameter search
// Three register stages: midpoint, squares, curve point and compare. A word
// that has already converged passes through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_search_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [17:0]                  thrx,
   input  wire  [16:0]                  ival,
   input  adc_pkg::search_word_type     word_in,
   output adc_pkg::search_word_type     word_out
);

   adc_pkg::search_word_type a_ff, a_in;
   adc_pkg::search_word_type b_ff;
   adc_pkg::search_word_type c_ff, c_in;
   logic [16:0] u_ff, u_in;
   logic [33:0] tu_ff, tu_in;
   logic [33:0] tt_ff, tt_in;
   logic [16:0] mid;
   logic [51:0] p_thr;
   logic [52:0] x_sum;
   logic [20:0] x_val;
   logic signed [21:0] diff;

   // take the midpoint of the interval
   always_comb begin
      mid  = 17'(word_in.lo + ((word_in.hi - word_in.lo) >> 1));
      a_in = word_in;
      if (!word_in.done) begin
         a_in.t = mid;
      end
      u_in = 17'(adc_pkg::Q16_ONE - {15'd0, a_in.t});
   end

   // form t*u and t*t
   assign tu_in = a_ff.t * u_ff;
   assign tt_in = a_ff.t * a_ff.t;

   // evaluate the curve abscissa and narrow the interval
   always_comb begin
      p_thr = tu_ff * thrx;
      x_sum = {p_thr, 1'b0} + {3'd0, tt_ff, 16'd0};
      x_val = x_sum[52:32];
      diff  = $signed({5'd0, ival}) - $signed({1'b0, x_val});
      c_in  = b_ff;
      if (!b_ff.done) begin
         if (diff > -22'sd66 && diff < 22'sd66) begin
            c_in.done = 1'b1;
         end else if ({4'd0, ival} < x_val) begin
            c_in.hi = b_ff.t;
         end else begin
            c_in.lo = b_ff.t;
         end
      end
   end

   // advance the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
      end else begin
         a_ff.valid <= a_in.valid;
         b_ff.valid <= a_ff.valid;
         c_ff.valid <= c_in.valid;
      end
      a_ff.done <= a_in.done;
      a_ff.lo   <= a_in.lo;
      a_ff.hi   <= a_in.hi;
      a_ff.t    <= a_in.t;
      u_ff      <= u_in;
      b_ff.done <= a_ff.done;
      b_ff.lo   <= a_ff.lo;
      b_ff.hi   <= a_ff.hi;
      b_ff.t    <= a_ff.t;
      tu_ff     <= tu_in;
      tt_ff     <= tt_in;
      c_ff.done <= c_in.done;
      c_ff.lo   <= c_in.lo;
      c_ff.hi   <= c_in.hi;
      c_ff.t    <= c_in.t;
   end

   assign word_out = c_ff;

endmodule

`default_nettype wire

// ----- rtl/core/audio_dynamics_compander_core.sv -----
// ----------------------------------------------------------------------------
// audio_dynamics_compander_core: two-slope compressor/expander with soft knee
// Modulated gains and threshold, hard or Bezier knee, saturated output.
// ----------------------------------------------------------------------------
// One sample is processed at a time: start is taken while busy is low, and the
// result appears on rsp_sample_out for exactly one cycle with rsp_valid high;
// it must be captured then, as the block cannot be held off. A hard-knee
// sample passes the modulation, knee, clamp, gain and output states; a
// soft-knee sample also runs through the row of search cells of three stages
// each and the final Bezier states. When the quiet-gain line passes unity the
// threshold is recomputed by a bit-serial divider before the gain state.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_dynamics_compander_core #(
   parameter int SAMPLE_BITS  = 16,
   parameter int SEARCH_STEPS = 10
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  signed [SAMPLE_BITS-1:0] req_sample_in,
   input  wire  [16:0]                   req_mod_loud,
   input  wire  [16:0]                   req_mod_quiet,
   input  wire  [16:0]                   req_mod_threshold,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  wire                           csr_write_en,
   input  wire  [2:0]                    csr_index,
   input  wire  [17:0]                   csr_write_data
);

   localparam int B      = SAMPLE_BITS;
   localparam int OW     = adc_pkg::OVAL_W;
   localparam int PROD_W = OW + B + 1;
   localparam logic signed [PROD_W-1:0] MAXP = PROD_W'((64'sd1 <<< (B-1)) - 64'sd1);
   localparam logic signed [PROD_W-1:0] MINN = PROD_W'(-(64'sd1 <<< (B-1)));
   localparam logic signed [B:0] SCALE_N = (B+1)'(64'sd1 <<< (B-1));
   localparam logic signed [B:0] SCALE_P = (B+1)'((64'sd1 <<< (B-1)) - 64'sd1);

   // configuration registers
   logic               mode_ff;
   logic [15:0]        lgb_ff, qgb_ff;
   logic signed [16:0] lgd_ff, qgd_ff;
   logic [16:0]        thb_ff;
   logic signed [17:0] thd_ff;

   adc_pkg::state_type state_ff, state_in;

   // item registers
   logic               neg_ff;
   logic [16:0]        ival_ff;
   logic [16:0]        ml_ff, mq_ff, mt_ff;
   logic [17:0]        rlo_ff, rqu_ff, thrx_ff;
   logic [35:0]        kprod_ff;
   logic [16:0]        thry_ff;
   logic [18:0]        rem_ff;
   logic [28:0]        q_ff;
   logic [4:0]         cnt_ff;
   logic signed [OW-1:0] endy_ff;
   logic signed [OW-1:0] oval_ff;
   logic [16:0]        tfin_ff;
   logic [33:0]        tu_ff, tt_ff;
   logic [50:0]        p1_ff;
   logic signed [62:0] p2_ff;
   logic               rsp_valid_ff;
   logic signed [B-1:0] rsp_data_ff;

   // sample magnitude and amplitude
   logic [B-1:0]       mag;
   logic [B+15:0]      amp_sh;

   always_comb begin
      mag    = req_sample_in[B-1] ? B'(-req_sample_in) : B'(req_sample_in);
      amp_sh = {mag, 16'd0} >> (B-1);
   end

   // modulation of gains and threshold
   logic signed [34:0] pl, pq;
   logic signed [35:0] pt;
   logic signed [34:0] pl_sh, pq_sh;
   logic signed [35:0] pt_sh;
   logic signed [21:0] sl, sq, st;

   always_comb begin
      pl = lgd_ff * $signed({1'b0, ml_ff});
      pq = qgd_ff * $signed({1'b0, mq_ff});
      pt = thd_ff * $signed({1'b0, mt_ff});
      pl_sh = (pl < 0) ? -((-pl) >>> 16) : (pl >>> 16);
      pq_sh = (pq < 0) ? -((-pq) >>> 16) : (pq >>> 16);
      pt_sh = (pt < 0) ? -((-pt) >>> 16) : (pt >>> 16);
      sl = $signed({6'd0, lgb_ff}) + pl_sh[21:0];
      sq = $signed({6'd0, qgb_ff}) + pq_sh[21:0];
      st = $signed({5'd0, thb_ff}) + pt_sh[21:0];
   end

   // bit-serial divider for the moved knee point
   logic [19:0] rem_sh;
   logic        q_bit;
   logic [19:0] rem_diff;

   always_comb begin
      rem_sh   = {rem_ff, (cnt_ff == 5'd28)};
      q_bit    = rem_sh >= {2'd0, rqu_ff};
      rem_diff = rem_sh - {2'd0, rqu_ff};
   end

   // hard-knee gain and soft-knee end point
   logic        above;
   logic [16:0] op_a;
   logic [17:0] op_b;
   logic [34:0] hprod;
   logic signed [OW-1:0] hard_oval;
   logic signed [19:0] ediff;
   logic signed [38:0] eprod, eprod_sh;
   logic signed [OW-1:0] endy_calc;

   always_comb begin
      above = {1'b0, ival_ff} >= thrx_ff;
      op_a  = above ? 17'(ival_ff - thrx_ff[16:0]) : ival_ff;
      op_b  = above ? rlo_ff : rqu_ff;
      hprod = op_a * op_b;
      hard_oval = above ? $signed(OW'({1'b0, thry_ff}) + OW'(hprod >> 12))
                        : $signed(OW'(hprod >> 12));
      ediff = $signed(20'(adc_pkg::Q16_ONE)) - $signed({2'd0, thrx_ff});
      eprod = ediff * $signed({1'b0, rlo_ff});
      eprod_sh = (eprod < 0) ? -((-eprod) >>> 12) : (eprod >>> 12);
      endy_calc = $signed(OW'({1'b0, thry_ff})) + eprod_sh[OW-1:0];
   end

   // row of search cells
   adc_pkg::search_word_type chain_w [SEARCH_STEPS+1];

   always_comb begin
      chain_w[0].valid = (state_ff == adc_pkg::ST_GAIN) && mode_ff;
      chain_w[0].done  = 1'b0;
      chain_w[0].lo    = 17'd0;
      chain_w[0].hi    = 17'(adc_pkg::Q16_ONE);
      chain_w[0].t     = 17'd0;
   end

   for (genvar g = 0; g < SEARCH_STEPS; g++) begin : g_cell
      adc_search_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .thrx     (thrx_ff),
         .ival     (ival_ff),
         .word_in  (chain_w[g]),
         .word_out (chain_w[g+1])
      );
   end

   // final Bezier ordinate
   logic signed [63:0] fsum, fsum_sh;
   logic [16:0]        ufin;

   always_comb begin
      ufin    = 17'(adc_pkg::Q16_ONE - {15'd0, tfin_ff});
      fsum    = $signed({12'd0, p1_ff, 1'b0}) + 64'(p2_ff);
      fsum_sh = (fsum < 0) ? -((-fsum) >>> 32) : (fsum >>> 32);
   end

   // output scaling and saturation
   logic signed [PROD_W-1:0] oprod, osh, ores;
   logic signed [B-1:0]      osat;

   always_comb begin
      oprod = oval_ff * (neg_ff ? SCALE_N : SCALE_P);
      osh   = (oprod < 0) ? -((-oprod) >>> 16) : (oprod >>> 16);
      ores  = neg_ff ? -osh : osh;
      if (ores > MAXP) begin
         osat = MAXP[B-1:0];
      end else if (ores < MINN) begin
         osat = MINN[B-1:0];
      end else begin
         osat = ores[B-1:0];
      end
   end

   // sequence one sample
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         adc_pkg::ST_IDLE:  if (start) state_in = adc_pkg::ST_MOD;
         adc_pkg::ST_MOD:   state_in = adc_pkg::ST_KNEE;
         adc_pkg::ST_KNEE:  state_in = adc_pkg::ST_CLAMP;
         adc_pkg::ST_CLAMP: begin
            state_in = (kprod_ff > 36'h1000_0000) ? adc_pkg::ST_DIV : adc_pkg::ST_GAIN;
         end
         adc_pkg::ST_DIV:   if (cnt_ff == 5'd0) state_in = adc_pkg::ST_GAIN;
         adc_pkg::ST_GAIN:  state_in = mode_ff ? adc_pkg::ST_CHAIN : adc_pkg::ST_OUT;
         adc_pkg::ST_CHAIN: if (chain_w[SEARCH_STEPS].valid) state_in = adc_pkg::ST_FIN1;
         adc_pkg::ST_FIN1:  state_in = adc_pkg::ST_FIN2;
         adc_pkg::ST_FIN2:  state_in = adc_pkg::ST_FIN3;
         adc_pkg::ST_FIN3:  state_in = adc_pkg::ST_OUT;
         adc_pkg::ST_OUT:   state_in = adc_pkg::ST_IDLE;
         default:           state_in = adc_pkg::ST_IDLE;
      endcase
   end

   // hold control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         lgb_ff       <= 16'd4096;
         lgd_ff       <= 17'sd0;
         qgb_ff       <= 16'd4096;
         qgd_ff       <= 17'sd0;
         thb_ff       <= 17'd32768;
         thd_ff       <= 18'sd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == adc_pkg::ST_OUT);
         if (csr_write_en) begin
            case (csr_index)
               adc_pkg::CSR_KNEE_MODE:   mode_ff <= csr_write_data[0];
               adc_pkg::CSR_LOUD_BASE:   lgb_ff  <= csr_write_data[15:0];
               adc_pkg::CSR_LOUD_DEPTH:  lgd_ff  <= $signed(csr_write_data[16:0]);
               adc_pkg::CSR_QUIET_BASE:  qgb_ff  <= csr_write_data[15:0];
               adc_pkg::CSR_QUIET_DEPTH: qgd_ff  <= $signed(csr_write_data[16:0]);
               adc_pkg::CSR_THR_BASE:    thb_ff  <= csr_write_data[16:0];
               adc_pkg::CSR_THR_DEPTH:   thd_ff  <= $signed(csr_write_data);
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         adc_pkg::ST_IDLE: begin
            neg_ff  <= req_sample_in[B-1];
            ival_ff <= amp_sh[16:0];
            ml_ff   <= req_mod_loud;
            mq_ff   <= req_mod_quiet;
            mt_ff   <= req_mod_threshold;
         end
         adc_pkg::ST_MOD: begin
            rlo_ff  <= (sl < 0) ? 18'd0 : sl[17:0];
            rqu_ff  <= (sq < 0) ? 18'd0 : sq[17:0];
            thrx_ff <= (st < 0) ? 18'd0 : st[17:0];
         end
         adc_pkg::ST_KNEE: begin
            kprod_ff <= rqu_ff * thrx_ff;
         end
         adc_pkg::ST_CLAMP: begin
            if (kprod_ff > 36'h1000_0000) begin
               thry_ff <= 17'(adc_pkg::Q16_ONE);
            end else begin
               thry_ff <= kprod_ff[28:12];
            end
            rem_ff <= 19'd0;
            q_ff   <= 29'd0;
            cnt_ff <= 5'd28;
         end
         adc_pkg::ST_DIV: begin
            rem_ff <= q_bit ? rem_diff[18:0] : rem_sh[18:0];
            q_ff   <= {q_ff[27:0], q_bit};
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               thrx_ff <= {q_ff[16:0], q_bit};
            end
         end
         adc_pkg::ST_GAIN: begin
            oval_ff <= hard_oval;
            endy_ff <= endy_calc;
         end
         adc_pkg::ST_CHAIN: begin
            tfin_ff <= chain_w[SEARCH_STEPS].t;
         end
         adc_pkg::ST_FIN1: begin
            tu_ff <= tfin_ff * ufin;
            tt_ff <= tfin_ff * tfin_ff;
         end
         adc_pkg::ST_FIN2: begin
            p1_ff <= tu_ff * thry_ff;
            p2_ff <= $signed({1'b0, tt_ff}) * endy_ff;
         end
         adc_pkg::ST_FIN3: begin
            oval_ff <= fsum_sh[OW-1:0];
         end
         adc_pkg::ST_OUT: begin
            rsp_data_ff <= osat;
         end
         default: ;
      endcase
   end

   assign busy           = (state_ff != adc_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // a result strobe lasts one cycle and the block is idle with it
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result strobe while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted word did not raise busy");
   a_chain_tail: assert property (@(posedge clock) disable iff (reset)
      chain_w[SEARCH_STEPS].valid |-> state_ff == adc_pkg::ST_CHAIN)
      else $error("search word left the cell row outside the search phase");

endmodule

`default_nettype wire
